// ===== rtl/core/sts_pkg.sv =====
// Shared types, constants and compare-exchange helpers for the two-of-four select.
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned NUM_POS  = 4;
   localparam int unsigned POS_W    = 2;
   localparam int unsigned MASK_W   = NUM_POS;
   localparam int unsigned REQ_W    = NUM_POS * VALUE_W;
   localparam int unsigned RSP_W    = 2 * VALUE_W + MASK_W;
   localparam int unsigned RSP_PAD_W = ((RSP_W + 7) / 8) * 8;

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [MASK_W-1:0]  mask_type;

   // Group positions, named so the sorting network reads as its pair list
   localparam pos_type P0 = 2'd0;
   localparam pos_type P1 = 2'd1;
   localparam pos_type P2 = 2'd2;
   localparam pos_type P3 = 2'd3;

   localparam value_type MAG_MASK = 32'h7FFF_FFFF;
   localparam value_type INF_BITS = 32'h7F80_0000;

   // Original values by position plus the current slot order
   typedef struct packed {
      value_type [NUM_POS-1:0] value;
      pos_type   [NUM_POS-1:0] slot;
   } pipe_word_type;

   // Result word, last field in the lowest bits
   typedef struct packed {
      mask_type  keep_mask;
      value_type kept_second_value;
      value_type kept_first_value;
   } result_type;

   // Strict float greater-than on sign-cleared patterns; any NaN gives false
   function automatic logic mag_greater(value_type a, value_type b);
      logic nan_seen;
      nan_seen = (a > INF_BITS) || (b > INF_BITS);
      return !nan_seen && (a > b);
   endfunction

   // One compare-exchange of slots i and j (i before j)
   function automatic pipe_word_type ce_step(pipe_word_type w, pos_type i, pos_type j);
      pipe_word_type r;
      value_type     mag_i;
      value_type     mag_j;
      r     = w;
      mag_i = w.value[w.slot[i]] & MAG_MASK;
      mag_j = w.value[w.slot[j]] & MAG_MASK;
      if (mag_greater(mag_i, mag_j)) begin
         r.slot[i] = w.slot[j];
         r.slot[j] = w.slot[i];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sts_sort_front.sv =====
// First two pipeline stages of the sorting network: pairs (0,1),(0,2) then (0,3),(1,2).
`timescale 1ns / 1ps
`default_nettype none

module sts_sort_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  sts_pkg::pipe_word_type in_word,
   output logic                   out_valid,
   input  wire                    out_ready,
   output sts_pkg::pipe_word_type out_word
);
   import sts_pkg::*;

   logic          s1_valid_ff, s1_valid_in;
   logic          s2_valid_ff, s2_valid_in;
   pipe_word_type s1_word_ff, s1_word_in;
   pipe_word_type s2_word_ff, s2_word_in;
   logic          s1_ready;
   logic          s2_ready;

   // A stage loads when it is empty or its word moves on this cycle
   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // Stage 1: compare-exchange (0,1) then (0,2)
   always_comb begin
      s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
      s1_word_in  = s1_word_ff;
      if (s1_ready && in_valid) begin
         s1_word_in = ce_step(ce_step(in_word, P0, P1), P0, P2);
      end
   end

   // Stage 2: compare-exchange (0,3) then (1,2)
   always_comb begin
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
      s2_word_in  = s2_word_ff;
      if (s2_ready && s1_valid_ff) begin
         s2_word_in = ce_step(ce_step(s1_word_ff, P0, P3), P1, P2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      s1_word_ff <= s1_word_in;
      s2_word_ff <= s2_word_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_word  = s2_word_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sts_sort_back.sv =====
// Last sorting stage, pairs (1,3),(2,3), then kept-pair selection into the output register.
`timescale 1ns / 1ps
`default_nettype none

module sts_sort_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  sts_pkg::pipe_word_type in_word,
   output logic                   out_valid,
   input  wire                    out_ready,
   output sts_pkg::result_type    out_result
);
   import sts_pkg::*;

   logic          valid_ff, valid_in;
   result_type    result_ff, result_in;
   pipe_word_type sorted;
   pos_type       lo_pos;
   pos_type       hi_pos;
   mask_type      mask;

   assign in_ready = !valid_ff || out_ready;

   // Finish the network; the last two slots hold the kept positions
   always_comb begin
      sorted = ce_step(ce_step(in_word, P1, P3), P2, P3);
      if (sorted.slot[P2] < sorted.slot[P3]) begin
         lo_pos = sorted.slot[P2];
         hi_pos = sorted.slot[P3];
      end else begin
         lo_pos = sorted.slot[P3];
         hi_pos = sorted.slot[P2];
      end
      mask         = '0;
      mask[lo_pos] = 1'b1;
      mask[hi_pos] = 1'b1;
   end

   // Output register, held while the receiver stalls
   always_comb begin
      valid_in  = in_ready ? in_valid : valid_ff;
      result_in = result_ff;
      if (in_ready && in_valid) begin
         result_in.kept_first_value  = sorted.value[lo_pos];
         result_in.kept_second_value = sorted.value[hi_pos];
         result_in.keep_mask         = mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sparse_two_of_four_select.sv =====
// Top level of the two-of-four magnitude prune: stream ports and pipeline hookup.
//
// Usage:
//   req_* carries one group of four fp32 bit patterns per word. Each group is
//   sorted by magnitude (sign cleared, NaN never swaps) and the two largest
//   positions are kept. rsp_* returns the kept values in ascending position
//   order and a four-bit keep mask with exactly two bits set.
// Path: an accepted req word passes two sorting-network stages plus the output
//   register before it shows on rsp_tvalid.
// Throughput: one group per cycle while the output is not stalled; every stage is a
//   register with its own valid bit, so a new word can enter each cycle while earlier ones are in flight.
// Reset: synchronous, clears all valid bits; words in flight are dropped.
// Stall: while rsp_tready is low the output word holds; upstream stages keep
//   filling empty slots, and req_tready drops only when all three are full.
//   req_tready is high whenever rsp_tready is high.
`timescale 1ns / 1ps
`default_nettype none

module sparse_two_of_four_select (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   // value_0 [31:0], value_1 [63:32], value_2 [95:64], value_3 [127:96]
   input  wire  [sts_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   // kept_first_value [31:0], kept_second_value [63:32], keep_mask [67:64], zero pad
   output logic [sts_pkg::RSP_PAD_W-1:0] rsp_tdata
);
   import sts_pkg::*;

   pipe_word_type in_word;
   pipe_word_type mid_word;
   logic          mid_valid;
   logic          mid_ready;
   result_type    result;

   // Unpack the group; slot order starts as the identity
   always_comb begin
      for (int p = 0; p < NUM_POS; p++) begin
         in_word.value[p] = req_tdata[p*VALUE_W +: VALUE_W];
         in_word.slot[p]  = pos_type'(p);
      end
   end

   sts_sort_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_word   (in_word),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_word  (mid_word)
   );

   sts_sort_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mid_valid),
      .in_ready   (mid_ready),
      .in_word    (mid_word),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {{(RSP_PAD_W-RSP_W){1'b0}}, result};

endmodule

`default_nettype wire

// ===== rtl/core/sts_checker.sv =====
// Port-level checker for the two-of-four select, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sts_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_tready,
   input wire                            rsp_tvalid,
   input wire                            rsp_tready,
   input wire [sts_pkg::RSP_PAD_W-1:0]   rsp_tdata
);
   import sts_pkg::*;

   // Every result keeps exactly two positions
   a_two_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones(rsp_tdata[RSP_W-1 -: MASK_W]) == 2)
      else $error("keep mask does not have exactly two bits set");

   // Pad bits above the mask stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_PAD_W-1:RSP_W] == '0)
      else $error("rsp pad bits not zero");

   // An open output lets every stage advance, so the input is open too
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("req_tready low while rsp_tready high");

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp word changed");

endmodule

bind sparse_two_of_four_select sts_checker u_sts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
